// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL decoder unit.
// Both macros expect a clock named clk_i and an active-low reset named rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_RUN(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PointW = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned RemW   = 2;

  // Result queue depth; one input word can push two results.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [PointW-1:0] ReplacementPoint = 21'h00FFFD;

  localparam logic [ByteW-1:0] AsciiLimit  = 8'h80;
  localparam logic [ByteW-1:0] ContMask    = 8'hC0;
  localparam logic [ByteW-1:0] ContTag     = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask   = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Tag    = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Bits   = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask   = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Tag    = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Bits   = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask   = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Tag    = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Bits   = 8'h07;
  localparam logic [ByteW-1:0] PayloadBits = 8'h3F;

  typedef struct packed {
    logic [PointW-1:0] code_point;
    logic [CountW-1:0] byte_count;
    logic              last;
  } result_t;

endpackage

// File: hw/rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder. Text enters one byte per word on the slave stream, with
// tlast marking the final byte of the text, and code points leave on the master
// stream, each with the number of bytes it consumed. Decoding is lax: overlong
// forms, surrogates and out-of-range values pass unchecked. Malformed input
// yields U+FFFD. A byte that breaks into an open sequence first closes that
// sequence as U+FFFD and is then decoded on its own, so one input word can give
// two results; master tlast marks the last result caused by an input word.
// Throughput is one input word per cycle as long as each word gives at most one
// result and the consumer does not stall; a word that gives two results needs an
// extra output transfer. An accepted input word waits in the input register, and
// the decode logic then writes its results into the four-entry result queue that
// feeds the master side. The input side stalls only when the result queue
// cannot take two more results. In that case a word already in the input
// register waits there, whole, until a stalled consumer frees enough entries;
// the decode step never pushes only part of the results of a word.
`include "assert_macros.svh"

module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] byte_count
  output logic        m_axis_tlast_o    // last
);

  // Input register.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_fin_q;

  // Sequence state.
  logic [RemW-1:0]   rem_q,   rem_d;
  logic [PointW-1:0] part_q,  part_d;
  logic [CountW-1:0] taken_q, taken_d;

  // Result queue.
  result_t              queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  result_t    res_c [2];
  logic [1:0] n_c;
  logic       consume;
  logic       pop;
  logic       s_fire;
  result_t    head;

  // The decode step may push two results, so it only proceeds when the
  // queue has at least two free entries.
  assign consume = in_valid_q && (count_q <= QueueCntW'(QueueDepth - 2));
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign head            = queue_q[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {head.byte_count, head.code_point};
  assign m_axis_tlast_o  = head.last;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  // Decode of one byte against the open sequence.
  always_comb begin
    logic start;
    logic [ByteW-1:0] b;
    start   = 1'b0;
    b       = in_byte_q;
    rem_d   = rem_q;
    part_d  = part_q;
    taken_d = taken_q;
    n_c     = 2'd0;
    res_c[0] = '0;
    res_c[1] = '0;

    if (rem_q != '0) begin
      if ((b & ContMask) == ContTag) begin
        part_d  = {part_q[PointW-7:0], b[5:0] & PayloadBits[5:0]};
        taken_d = taken_q + CountW'(1);
        rem_d   = rem_q - RemW'(1);
        if (rem_d == '0) begin
          res_c[n_c[0]] = '{code_point: part_d, byte_count: taken_d, last: 1'b0};
          n_c     = n_c + 2'd1;
          part_d  = '0;
          taken_d = '0;
        end
      end else begin
        // Interrupted sequence: close it, then decode this byte as a lead.
        res_c[n_c[0]] = '{code_point: ReplacementPoint, byte_count: taken_q, last: 1'b0};
        n_c     = n_c + 2'd1;
        rem_d   = '0;
        part_d  = '0;
        taken_d = '0;
        start   = 1'b1;
      end
    end else begin
      start = 1'b1;
    end

    if (start) begin
      if (b < AsciiLimit) begin
        res_c[n_c[0]] = '{code_point: PointW'(b), byte_count: CountW'(1), last: 1'b0};
        n_c = n_c + 2'd1;
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        part_d  = PointW'(b & Lead2Bits);
        rem_d   = RemW'(1);
        taken_d = CountW'(1);
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        part_d  = PointW'(b & Lead3Bits);
        rem_d   = RemW'(2);
        taken_d = CountW'(1);
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        part_d  = PointW'(b & Lead4Bits);
        rem_d   = RemW'(3);
        taken_d = CountW'(1);
      end else begin
        res_c[n_c[0]] = '{code_point: ReplacementPoint, byte_count: CountW'(1), last: 1'b0};
        n_c = n_c + 2'd1;
      end
    end

    // End of text with a sequence still open flushes it.
    if (in_fin_q && (rem_d != '0)) begin
      res_c[n_c[0]] = '{code_point: ReplacementPoint, byte_count: taken_d, last: 1'b0};
      n_c     = n_c + 2'd1;
      rem_d   = '0;
      part_d  = '0;
      taken_d = '0;
    end

    res_c[0].last = (n_c == 2'd1);
    res_c[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      rem_q      <= '0;
      part_q     <= '0;
      taken_q    <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (consume) begin
        rem_q    <= rem_d;
        part_q   <= part_d;
        taken_q  <= taken_d;
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_c);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_q + (consume ? QueueCntW'(n_c) : '0) - (pop ? QueueCntW'(1) : '0);
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_fin_q  <= s_axis_tlast_i;
    end
    if (consume && (n_c != 2'd0)) begin
      queue_q[wr_ptr_q] <= res_c[0];
    end
    if (consume && (n_c == 2'd2)) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= res_c[1];
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, count_q <= QueueCntW'(QueueDepth), "result queue overflow")
  `ASSERT_RUN(a_idle_state,
              (rem_q == '0) |-> (taken_q == '0 && part_q == '0),
              "stale sequence state")
  `ASSERT_RUN(a_open_taken,
              (rem_q != '0) |-> (taken_q != '0 && taken_q <= CountW'(3)),
              "bad byte count in open sequence")
  `ASSERT_RUN(a_pair_queued,
              (m_axis_tvalid_o && !m_axis_tlast_o) |-> (count_q >= QueueCntW'(2)),
              "first of a result pair without its partner")
  `ASSERT_RUN(a_count_range,
              m_axis_tvalid_o |-> (head.byte_count != '0 && head.byte_count <= CountW'(4)),
              "result byte count out of range")

endmodule
